// ===== src/lmns_pkg.sv =====
// Package for the label map nearest search block.
// Holds the field widths, operation and register codes, controller states and the
// command and status structs. Depends on nothing.
`default_nettype none

package lmns_pkg;

	localparam int DIM_W   = 7;
	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 12;
	localparam int COMP_W  = 8;
	localparam int COORD_W = 8;
	localparam int RAD_W   = 7;
	localparam int OFS_W   = 8;
	localparam int POS_W   = 9;
	localparam int LIN_W   = 14;
	localparam int ENTRY_W = 10;
	localparam int OWNED_B = 9;
	localparam int SCR_B   = 8;
	localparam int CIDX_W  = 1;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [CIDX_W-1:0] REG_FIELD_WIDTH  = 1'b0;
	localparam logic [CIDX_W-1:0] REG_FIELD_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_RST_CLR,
		ST_IDLE,
		ST_CLR,
		ST_INS_CHK,
		ST_INS_WR,
		ST_Q_SCAN,
		ST_Q_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_write;
		logic invalidate;
		logic ins_write;
		logic scan_step;
		logic next_ring;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic map_valid;
		logic ins_in_range;
		logic clr_last;
		logic ring_last;
		logic busy;
		logic hit_owned;
		logic ring_at_bound;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== src/lmns_ctrl.sv =====
// Controller for the label map nearest search block.
// Sequences clear sweeps, insert read-modify-write and ring scans; drives
// the datapath through cmd_t and reads status_t. Depends on lmns_pkg.
`default_nettype none

module lmns_ctrl
	import lmns_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [FUNC_W-1:0] func,
	input  wire status_t           status,
	output cmd_t                   cmd,
	output logic                   in_stall
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RST_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_RST_CLR: begin
				if (status.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_CLEAR:  state_nx = ST_CLR;
						FUNC_INSERT: state_nx = ST_INS_CHK;
						FUNC_QUERY:  state_nx = status.map_valid ? ST_Q_SCAN : ST_FIN;
						default:     state_nx = ST_FIN;
					endcase
				end
			end
			ST_CLR: begin
				if (status.clr_last) state_nx = ST_FIN;
			end
			ST_INS_CHK: begin
				state_nx = status.ins_in_range ? ST_INS_WR : ST_FIN;
			end
			ST_INS_WR: begin
				state_nx = ST_FIN;
			end
			ST_Q_SCAN: begin
				if (status.ring_last) state_nx = ST_Q_DRAIN;
			end
			ST_Q_DRAIN: begin
				if (!status.busy) begin
					state_nx = (status.hit_owned || status.ring_at_bound) ? ST_FIN : ST_Q_SCAN;
				end
			end
			ST_FIN: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_RST_CLR: cmd.clr_write = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_CLR:     cmd.clr_write = 1'b1;
			ST_INS_CHK: cmd.invalidate = !status.ins_in_range;
			ST_INS_WR:  cmd.ins_write = 1'b1;
			ST_Q_SCAN:  cmd.scan_step = 1'b1;
			ST_Q_DRAIN: begin
				cmd.next_ring = !status.busy && !status.hit_owned && !status.ring_at_bound;
			end
			ST_FIN:     cmd.result_load = status.out_free;
			default:    cmd = '0;
		endcase
	end

	a_scan_needs_valid_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_SCAN) |-> status.map_valid)
		else $error("ring scan while map invalid");

	a_write_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_WR) |-> $past(state_q == ST_INS_CHK && status.ins_in_range))
		else $error("insert write without in-range check");

	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input open while an item is in flight");

endmodule

`default_nettype wire

// ===== src/lmns_dpath.sv =====
// Datapath for the label map nearest search block.
// Holds the dimension registers, the label memory, the ring scan counters and
// read pipeline, and the output register. Depends on lmns_pkg.
`default_nettype none

module lmns_dpath
	import lmns_pkg::*;
#(
	parameter int MAX_DIM     = 64,
	parameter int MAP_ENTRIES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [IDX_W-1:0]   label_index,
	input  wire logic [COMP_W-1:0]  label_component,
	input  wire logic               label_is_scratch,
	input  wire logic signed [COORD_W-1:0] query_x,
	input  wire logic signed [COORD_W-1:0] query_y,
	input  wire logic [RAD_W-1:0]   search_radius,
	input  wire logic               out_stall,
	input  wire cmd_t               cmd,
	output status_t                 status,
	output logic                    out_valid,
	output logic                    found,
	output logic [COMP_W-1:0]       found_component,
	output logic                    map_ok
);

	localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam logic [DIM_W-1:0] DIM_RST = (64 > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(64);

	logic [DIM_W-1:0] width_q, height_q;
	logic             map_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [COMP_W-1:0] comp_q;
	logic             scr_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic [RAD_W-1:0] bound_q, ring_q;
	logic signed [OFS_W-1:0] dy_q, dx_q;
	logic [ENTRY_W-1:0] hit_q;
	logic [AW-1:0]    clr_addr_q;

	logic             valid_s1, ok_s1;
	logic [AW-1:0]    addr_s1;
	logic             valid_s2, ok_s2;
	logic [ENTRY_W-1:0] rd_data_s2;

	logic             out_valid_q, found_q, map_ok_q;
	logic [COMP_W-1:0] found_comp_q;

	logic [ENTRY_W-1:0] mem_q [MAP_ENTRIES];

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIELD_WIDTH:  width_q  <= clamp_dim(cfg_data);
				REG_FIELD_HEIGHT: height_q <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	// item capture and search bound
	logic [DIM_W-1:0] dim_max;
	logic [RAD_W-1:0] bound_nx;
	assign dim_max  = (width_q > height_q) ? width_q : height_q;
	assign bound_nx = (search_radius < dim_max) ? search_radius : dim_max;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q   <= label_index;
			comp_q  <= label_component;
			scr_q   <= label_is_scratch;
			qx_q    <= query_x;
			qy_q    <= query_y;
		end
	end

	// insert range check and take rule
	logic [LIN_W-1:0] area;
	logic             take;
	logic             old_owned, old_scr;
	assign area = LIN_W'(width_q) * LIN_W'(height_q);
	assign status.ins_in_range = (LIN_W'(idx_q) < area) && (32'(idx_q) < 32'(MAP_ENTRIES));
	assign old_owned = rd_data_s2[OWNED_B];
	assign old_scr   = rd_data_s2[SCR_B];

	always_comb begin
		if (!old_owned) begin
			take = 1'b1;
		end else if (old_scr != scr_q) begin
			take = !scr_q;
		end else begin
			take = comp_q < rd_data_s2[COMP_W-1:0];
		end
	end

	// ring walk
	logic signed [OFS_W-1:0] d, d_nx;
	logic [RAD_W-1:0] ring_nx;
	logic             edge_row, at_right;
	assign ring_nx  = ring_q + 1'b1;
	assign d        = $signed({1'b0, ring_q});
	assign d_nx     = $signed({1'b0, ring_nx});
	assign edge_row = (dy_q == d) || (dy_q == -d);
	assign at_right = (dx_q == d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= 1'b1;
			clr_addr_q  <= '0;
			ring_q      <= '0;
			bound_q     <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			hit_q       <= '0;
		end else begin
			if (cmd.accept) begin
				ring_q  <= '0;
				bound_q <= bound_nx;
				dy_q    <= '0;
				dx_q    <= '0;
				hit_q   <= '0;
				if (func == FUNC_CLEAR) begin
					map_valid_q <= 1'b1;
					clr_addr_q  <= '0;
				end
			end
			if (cmd.invalidate) map_valid_q <= 1'b0;
			if (cmd.clr_write) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.scan_step) begin
				if (!at_right) begin
					dx_q <= edge_row ? dx_q + 1'b1 : d;
				end else if (dy_q != d) begin
					dy_q <= dy_q + 1'b1;
					dx_q <= -d;
				end
			end
			if (cmd.next_ring) begin
				ring_q <= ring_nx;
				dy_q   <= -d_nx;
				dx_q   <= -d_nx;
			end
			if (valid_s2 && ok_s2 && rd_data_s2[OWNED_B]) hit_q <= rd_data_s2;
		end
	end

	// cell address stage
	logic signed [POS_W-1:0] x_pos, y_pos;
	logic             in_field;
	logic [LIN_W-1:0] lin;
	assign x_pos    = POS_W'(qx_q) + POS_W'(dx_q);
	assign y_pos    = POS_W'(qy_q) + POS_W'(dy_q);
	assign in_field = !x_pos[POS_W-1] && !y_pos[POS_W-1]
		&& (x_pos[POS_W-2:0] < {1'b0, width_q}) && (y_pos[POS_W-2:0] < {1'b0, height_q});
	assign lin = LIN_W'(y_pos[DIM_W-1:0]) * LIN_W'(width_q) + LIN_W'(x_pos[DIM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_step;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= in_field && (32'(lin) < 32'(MAP_ENTRIES));
		addr_s1 <= AW'(lin);
		ok_s2   <= ok_s1;
	end

	// label memory
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               wr_en;
	assign rd_addr = valid_s1 ? addr_s1 : AW'(idx_q);
	assign wr_en   = cmd.clr_write || (cmd.ins_write && take);
	assign wr_addr = cmd.clr_write ? clr_addr_q : AW'(idx_q);
	assign wr_data = cmd.clr_write ? '0 : {1'b1, scr_q, comp_q};

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_s2 <= mem_q[rd_addr];
	end

	// output register
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			found_q      <= hit_q[OWNED_B];
			found_comp_q <= hit_q[OWNED_B] ? hit_q[COMP_W-1:0] : '0;
			map_ok_q     <= map_valid_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign found_component = found_comp_q;
	assign map_ok          = map_ok_q;

	assign status.map_valid     = map_valid_q;
	assign status.clr_last      = (32'(clr_addr_q) == 32'(MAP_ENTRIES - 1));
	assign status.ring_last     = at_right && (dy_q == d);
	assign status.busy          = valid_s1 || valid_s2;
	assign status.hit_owned     = hit_q[OWNED_B];
	assign status.ring_at_bound = (ring_q == bound_q);
	assign status.out_free      = out_free;

	a_ring_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q <= bound_q)
		else $error("ring beyond search bound");

	a_read_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("read stage without address stage");

	a_load_shows_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> out_valid_q)
		else $error("loaded item not presented");

endmodule

`default_nettype wire

// ===== src/label_map_nearest_search.sv =====
// Label map nearest search: one item in, one result item out, one item in flight at a time.
// After reset the block sweeps the label memory with in_stall high; a clear item repeats
// that sweep. An insert is a read and a conditional write through the memory port, with no
// write when its index is out of field. A query scans rings d outward from d = 0 (the point
// itself), max(1, 8*d) cells per ring, one read per ring cell through the single read port,
// then drains the read pipeline and decides the next ring. Output stall cycles add to the
// item waiting behind them; the next item is accepted while the previous result waits at
// the output.
`default_nettype none

module label_map_nearest_search
	import lmns_pkg::*;
#(
	parameter int MAX_DIM     = 64,
	parameter int MAP_ENTRIES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [IDX_W-1:0]   label_index,
	input  wire logic [COMP_W-1:0]  label_component,
	input  wire logic               label_is_scratch,
	input  wire logic signed [COORD_W-1:0] query_x,
	input  wire logic signed [COORD_W-1:0] query_y,
	input  wire logic [RAD_W-1:0]   search_radius,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	output logic [COMP_W-1:0]       found_component,
	output logic                    map_ok
);

	cmd_t    cmd;
	status_t status;

	lmns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	lmns_dpath #(
		.MAX_DIM     (MAX_DIM),
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.func             (func),
		.label_index      (label_index),
		.label_component  (label_component),
		.label_is_scratch (label_is_scratch),
		.query_x          (query_x),
		.query_y          (query_y),
		.search_radius    (search_radius),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_valid),
		.found            (found),
		.found_component  (found_component),
		.map_ok           (map_ok)
	);

endmodule

`default_nettype wire

// ===== verif/label_map_checker.sv =====
// Checker for label_map_nearest_search: tracks register writes and both item channels.
// Keeps its own label map, works out each result on input accept, compares on output accept.
// Depends on lmns_pkg.
module label_map_checker
	import lmns_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CIDX_W-1:0]         cfg_index,
	input  wire logic [DIM_W-1:0]          cfg_data,
	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire logic [FUNC_W-1:0]         func,
	input  wire logic [IDX_W-1:0]          label_index,
	input  wire logic [COMP_W-1:0]         label_component,
	input  wire logic                      label_is_scratch,
	input  wire logic signed [COORD_W-1:0] query_x,
	input  wire logic signed [COORD_W-1:0] query_y,
	input  wire logic [RAD_W-1:0]          search_radius,
	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire logic                      found,
	input  wire logic [COMP_W-1:0]         found_component,
	input  wire logic                      map_ok,
	output int                             errors,
	output int                             pending,
	output int                             hits
);

	localparam int FIELD_MAX = 64;
	localparam int MAP_SIZE  = 4096;

	typedef struct packed {
		logic              found;
		logic [COMP_W-1:0] comp;
		logic              ok;
	} answer_t;

	logic [ENTRY_W-1:0] label_mem [MAP_SIZE];
	logic               map_valid_q;
	int                 width_q;
	int                 height_q;
	answer_t            answers_due [$];

	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > FIELD_MAX)
			return FIELD_MAX;
		return int'(v);
	endfunction

	function automatic logic [ENTRY_W-1:0] cell_at(int x, int y);
		if (x < 0 || y < 0 || x >= width_q || y >= height_q)
			return '0;
		return label_mem[y * width_q + x];
	endfunction

	// rings scanned row-major, last owned cell on the first ring with an owner wins
	function automatic logic [ENTRY_W-1:0] nearest_owner(int qx, int qy, int rad);
		logic [ENTRY_W-1:0] best;
		logic [ENTRY_W-1:0] e;
		int bound;
		best = cell_at(qx, qy);
		bound = (width_q > height_q) ? width_q : height_q;
		if (rad < bound)
			bound = rad;
		for (int d = 1; d <= bound && !best[OWNED_B]; d++) begin
			for (int dy = -d; dy <= d; dy++) begin
				for (int dx = -d; dx <= d; dx++) begin
					if (dx == -d || dx == d || dy == -d || dy == d) begin
						e = cell_at(qx + dx, qy + dy);
						if (e[OWNED_B])
							best = e;
					end
				end
			end
		end
		return best;
	endfunction

	function automatic answer_t answer_for_item(logic [FUNC_W-1:0] op,
			logic [IDX_W-1:0] idx, logic [COMP_W-1:0] comp, logic scr,
			logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qy,
			logic [RAD_W-1:0] rad);
		logic [ENTRY_W-1:0] hit;
		logic [ENTRY_W-1:0] old;
		logic take;
		answer_t a;
		hit = '0;
		case (op)
			FUNC_CLEAR: begin
				foreach (label_mem[i])
					label_mem[i] = '0;
				map_valid_q = 1'b1;
			end
			FUNC_INSERT: begin
				if (int'(idx) >= width_q * height_q) begin
					map_valid_q = 1'b0;
				end else begin
					old = label_mem[idx];
					// dust beats scratch, then lower component wins
					if (!old[OWNED_B])
						take = 1'b1;
					else if (old[SCR_B] != scr)
						take = !scr;
					else
						take = comp < old[COMP_W-1:0];
					if (take)
						label_mem[idx] = {1'b1, scr, comp};
				end
			end
			FUNC_QUERY: begin
				if (map_valid_q)
					hit = nearest_owner(int'(qx), int'(qy), int'(rad));
			end
			default: ;
		endcase
		a.found = hit[OWNED_B];
		a.comp  = hit[OWNED_B] ? hit[COMP_W-1:0] : '0;
		a.ok    = map_valid_q;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (label_mem[i])
				label_mem[i] = '0;
			map_valid_q = 1'b1;
			width_q = FIELD_MAX;
			height_q = FIELD_MAX;
			answers_due.delete();
			errors = 0;
			pending = 0;
			hits = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FIELD_WIDTH)
					width_q = clamp_dim(cfg_data);
				else if (cfg_index == REG_FIELD_HEIGHT)
					height_q = clamp_dim(cfg_data);
			end
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result with no item outstanding: found %0d component %0d map_ok %0d",
						found, found_component, map_ok);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						errors++;
					end
					if (found_component !== want.comp) begin
						$error("found_component: expected %0d, got %0d", want.comp,
							found_component);
						errors++;
					end
					if (map_ok !== want.ok) begin
						$error("map_ok: expected %0d, got %0d", want.ok, map_ok);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = answer_for_item(func, label_index, label_component, label_is_scratch,
					query_x, query_y, search_radius);
				if (want.found)
					hits++;
				answers_due = {answers_due, want};
			end
			pending = answers_due.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the label_map_nearest_search testbench: clock, reset, register writes, item stimulus.
// Directed items first, then phases of clear/fill/query episodes over several field sizes.
// Depends on lmns_pkg, label_map_nearest_search and label_map_checker.
module testbench;
	import lmns_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int MAP_SIZE       = 4096;
	localparam int FIELD_MAX      = 64;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0]         op;
		logic [IDX_W-1:0]          idx;
		logic [COMP_W-1:0]         comp;
		logic                      scr;
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic [RAD_W-1:0]          rad;
	} item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CIDX_W-1:0]         cfg_index = '0;
	logic [DIM_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [FUNC_W-1:0]         func = '0;
	logic [IDX_W-1:0]          label_index = '0;
	logic [COMP_W-1:0]         label_component = '0;
	logic                      label_is_scratch = 1'b0;
	logic signed [COORD_W-1:0] query_x = '0;
	logic signed [COORD_W-1:0] query_y = '0;
	logic [RAD_W-1:0]          search_radius = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      found;
	logic [COMP_W-1:0]         found_component;
	logic                      map_ok;

	int errors;
	int pending;
	int hits;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int op_count [4] = '{0, 0, 0, 0};
	int random_count = 0;
	int width_now = FIELD_MAX;
	int height_now = FIELD_MAX;
	int used_cells [$];

	label_map_nearest_search dut (.*);

	label_map_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic int clamp_dim(int v);
		if (v == 0)
			return 1;
		if (v > FIELD_MAX)
			return FIELD_MAX;
		return v;
	endfunction

	function automatic item_t noise_item(logic [FUNC_W-1:0] op);
		item_t it;
		it.op   = op;
		it.idx  = IDX_W'($urandom);
		it.comp = COMP_W'($urandom);
		it.scr  = 1'($urandom);
		it.qx   = COORD_W'($urandom);
		it.qy   = COORD_W'($urandom);
		it.rad  = RAD_W'($urandom);
		return it;
	endfunction

	function automatic item_t mk(logic [FUNC_W-1:0] op, int idx, int comp, bit scr,
			int qx, int qy, int rad);
		item_t it;
		it = noise_item(op);
		if (op == FUNC_INSERT) begin
			it.idx  = IDX_W'(idx);
			it.comp = COMP_W'(comp);
			it.scr  = scr;
		end
		if (op == FUNC_QUERY) begin
			it.qx  = COORD_W'(qx);
			it.qy  = COORD_W'(qy);
			it.rad = RAD_W'(rad);
		end
		return it;
	endfunction

	function automatic item_t insert_item(bit in_field);
		item_t it;
		int area;
		it = noise_item(FUNC_INSERT);
		area = width_now * height_now;
		if (!in_field && area < MAP_SIZE) begin
			it.idx = IDX_W'($urandom_range(MAP_SIZE - 1, area));
		end else begin
			if (used_cells.size() != 0 && $urandom_range(99) < 30)
				it.idx = IDX_W'(used_cells[$urandom_range(used_cells.size() - 1)]);
			else
				it.idx = IDX_W'($urandom_range(area - 1));
			// narrow component range so ownership contests matter
			if ($urandom_range(1))
				it.comp = COMP_W'($urandom_range(15));
			used_cells = {used_cells, int'(it.idx)};
			if (used_cells.size() > 48)
				void'(used_cells.pop_front());
		end
		return it;
	endfunction

	function automatic item_t query_item();
		item_t it;
		int sel;
		int spot;
		int span;
		it = noise_item(FUNC_QUERY);
		span = (width_now > height_now) ? width_now : height_now;
		sel = $urandom_range(99);
		if (sel < 65 && used_cells.size() != 0) begin
			spot = used_cells[$urandom_range(used_cells.size() - 1)];
			it.qx = COORD_W'(spot % width_now + int'($urandom_range(6)) - 3);
			it.qy = COORD_W'(spot / width_now + int'($urandom_range(6)) - 3);
		end else if (sel < 90) begin
			it.qx = COORD_W'(int'($urandom_range(width_now + 1)) - 1);
			it.qy = COORD_W'(int'($urandom_range(height_now + 1)) - 1);
		end
		// wide rings are slow on big fields, so keep those rare
		if (span <= 16)
			it.rad = ($urandom_range(99) < 70) ? RAD_W'($urandom_range(span + 1)) : it.rad;
		else if ($urandom_range(99) >= 2)
			it.rad = RAD_W'($urandom_range(5));
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		func             <= it.op;
		label_index      <= it.idx;
		label_component  <= it.comp;
		label_is_scratch <= it.scr;
		query_x          <= it.qx;
		query_y          <= it.qy;
		search_radius    <= it.rad;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		op_count[it.op]++;
		if (it.op != FUNC_UNUSED)
			random_count++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_field(input int w_raw, input int h_raw);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIELD_WIDTH;
		cfg_data  <= DIM_W'(w_raw);
		@(negedge clk);
		cfg_index <= REG_FIELD_HEIGHT;
		cfg_data  <= DIM_W'(h_raw);
		@(negedge clk);
		cfg_we <= 1'b0;
		width_now = clamp_dim(w_raw);
		height_now = clamp_dim(h_raw);
		used_cells.delete();
		@(negedge clk);
	endtask

	task automatic run_episode(input bit squeeze);
		int fills;
		int mixes;
		int sel;
		send_item(noise_item(FUNC_CLEAR));
		used_cells.delete();
		fills = $urandom_range(30, 6);
		repeat (fills) send_item(insert_item(1'b1));
		if (squeeze) begin
			hold_requests++;
			repeat (10) send_item(insert_item(1'b1));
		end
		mixes = $urandom_range(40, 15);
		repeat (mixes) begin
			sel = $urandom_range(99);
			if (sel < 55)
				send_item(query_item());
			else if (sel < 94)
				send_item(insert_item(1'b1));
			else if (sel < 99)
				send_item(noise_item(FUNC_UNUSED));
			else
				send_item(insert_item(1'b0));
		end
		// now and then break the map and keep poking it
		if ($urandom_range(99) < 30) begin
			send_item(insert_item(1'b0));
			repeat ($urandom_range(6, 2)) begin
				if ($urandom_range(1))
					send_item(query_item());
				else
					send_item(insert_item(1'b1));
			end
		end
	endtask

	initial begin
		int w_plan [6];
		int h_plan [6];
		int phase;
		int w_raw;
		int h_raw;

		w_plan = '{8, 0, 127, 64, 1, 5};
		h_plan = '{8, 127, 0, 64, 1, 13};
		phase = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);

		// ownership rules on one pixel, corners and far-off query points
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 0, 10, 0, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 0, 5, 1, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 0, 3, 0, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 0, 7, 0, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 4095, 255, 1, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 4095, 0, 1, 0, 0, 0));
		send_item(mk(FUNC_INSERT, 4094, 200, 0, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 62, 62, 1));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 127, 127, 127));
		send_item(mk(FUNC_QUERY, 0, 0, 0, -128, -128, 127));
		send_item(mk(FUNC_QUERY, 0, 0, 0, -1, -1, 1));
		send_item(mk(FUNC_QUERY, 0, 0, 0, -2, 5, 0));
		send_item(noise_item(FUNC_UNUSED));
		settle();

		// out-of-range register values, out-of-field insert, invalid map
		set_field(0, 127);
		send_item(mk(FUNC_INSERT, 63, 9, 0, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 62, 1));
		send_item(mk(FUNC_INSERT, 4095, 1, 0, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 63, 0));
		send_item(mk(FUNC_INSERT, 5, 2, 1, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 5, 2));
		send_item(noise_item(FUNC_UNUSED));
		send_item(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
		send_item(mk(FUNC_QUERY, 0, 0, 0, 0, 5, 3));

		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			settle();
			if (phase < 6) begin
				w_raw = w_plan[phase];
				h_raw = h_plan[phase];
			end else if ($urandom_range(99) < 15) begin
				w_raw = $urandom_range(127, 17);
				h_raw = $urandom_range(16, 1);
				if ($urandom_range(1)) begin
					h_raw = w_raw;
					w_raw = $urandom_range(16, 1);
				end
			end else begin
				w_raw = $urandom_range(16, 2);
				h_raw = $urandom_range(16, 2);
			end
			set_field(w_raw, h_raw);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			run_episode(phase % 3 == 0);
			if ($urandom_range(2) == 0)
				settle();
			run_episode(1'b0);
			phase++;
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("covered %0d clears, %0d inserts, %0d queries (%0d found an owner), %0d unused codes",
			op_count[FUNC_CLEAR], op_count[FUNC_INSERT], op_count[FUNC_QUERY], hits,
			op_count[FUNC_UNUSED]);
		$display("over %0d field settings from 1x1 to 64x64, with stalls, gaps and long hold-offs",
			phase + 2);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
